[sv/fpsq_pkg.sv]
package fpsq_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int PRIO_BITS_DEF = 16;
	localparam int ARRIVAL_W     = 32;
	localparam int OPCODE_W      = 2;
	localparam int PRIO_REQ_W    = 16;
	localparam int STATUS_W      = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_OLDEST   = 2'd1,
		OP_PRIO     = 2'd2,
		OP_PRIO_ALT = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_SERVED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic    req_load;
		logic    ins_write;
		logic    res_load;
		status_t res_status;
		logic    scan_start;
		logic    scan_oldest;
		logic    scan_run;
		logic    clear_wait;
		logic    trim_adv;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic out_free;
		logic scan_done;
		logic trim_stop;
	} sts_t;

endpackage

[sv/fpsq_ctrl.sv]
module fpsq_ctrl
	import fpsq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [OPCODE_W-1:0] opcode,
	output logic                in_ready,
	output cmd_t                cmd,
	input  sts_t                sts
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_INS      = 7'b0000010,
		S_EMPTY    = 7'b0000100,
		S_SCAN     = 7'b0001000,
		S_SERVE    = 7'b0010000,
		S_TRIM_RD  = 7'b0100000,
		S_TRIM_CHK = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_INSERT) begin
						cmd.req_load = 1'b1;
						state_nxt    = S_INS;
					end else if (sts.empty) begin
						state_nxt = S_EMPTY;
					end else begin
						cmd.scan_start  = 1'b1;
						cmd.scan_oldest = (opcode == OP_OLDEST);
						state_nxt       = S_SCAN;
					end
				end
			end
			S_INS: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					if (sts.full) begin
						cmd.res_status = ST_FULL;
					end else begin
						cmd.res_status = ST_INSERTED;
						cmd.ins_write  = 1'b1;
					end
					state_nxt = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (sts.out_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_EMPTY;
					state_nxt      = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_nxt = S_SERVE;
				end
			end
			S_SERVE: begin
				if (sts.out_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_SERVED;
					cmd.clear_wait = 1'b1;
					state_nxt      = S_TRIM_RD;
				end
			end
			S_TRIM_RD: begin
				state_nxt = S_TRIM_CHK;
			end
			S_TRIM_CHK: begin
				if (sts.trim_stop) begin
					state_nxt = S_IDLE;
				end else begin
					cmd.trim_adv = 1'b1;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[sv/fpsq_dpath.sv]
module fpsq_dpath
	import fpsq_pkg::*;
#(
	parameter int DEPTH         = DEPTH_DEF,
	parameter int PRIORITY_BITS = PRIO_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PRIO_REQ_W-1:0] priority_req,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [ARRIVAL_W-1:0]  entry_number,
	output logic [STATUS_W-1:0]   status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = PRIORITY_BITS + ARRIVAL_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + AW'(1);
	endfunction

	logic [EW-1:0] ent_mem [DEPTH];
	logic          wait_mem [DEPTH];

	logic [AW-1:0]            head_q;
	logic [AW-1:0]            tail_q;
	logic [CW-1:0]            used_q;
	logic [ARRIVAL_W-1:0]     next_arr_q;
	logic [AW-1:0]            scan_ptr_q;
	logic [CW-1:0]            iss_cnt_q;
	logic                     rd_v_s1;
	logic [AW-1:0]            slot_s1;
	logic                     found_q;
	logic [PRIORITY_BITS-1:0] best_prio_q;
	logic [ARRIVAL_W-1:0]     best_arr_q;
	logic [AW-1:0]            best_slot_q;
	logic [EW-1:0]            ent_rd_q;
	logic                     wait_rd_q;
	logic                     out_valid_q;
	logic [ARRIVAL_W-1:0]     number_q;
	status_t                  status_q;
	logic [PRIORITY_BITS-1:0] prio_q;

	logic [AW-1:0]            rd_addr;
	logic [AW-1:0]            head_nxt;
	logic                     issue;
	logic [31:0]              prio_ext;
	logic [PRIORITY_BITS-1:0] prio_in;
	logic [PRIORITY_BITS-1:0] rd_prio;
	logic [ARRIVAL_W-1:0]     rd_arr;
	logic                     take;

	assign head_nxt = slot_next(head_q);
	assign issue    = cmd.scan_run && (iss_cnt_q != '0);
	assign prio_ext = {{(32 - PRIO_REQ_W){1'b0}}, priority_req};
	assign prio_in  = prio_ext[PRIORITY_BITS-1:0];
	assign rd_prio  = ent_rd_q[EW-1:ARRIVAL_W];
	assign rd_arr   = ent_rd_q[ARRIVAL_W-1:0];
	assign take     = rd_v_s1 && wait_rd_q && (!found_q || (rd_prio > best_prio_q));

	always_comb begin
		priority if (issue) begin
			rd_addr = scan_ptr_q;
		end else if (cmd.trim_adv) begin
			rd_addr = head_nxt;
		end else begin
			rd_addr = head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			ent_mem[tail_q] <= {prio_q, next_arr_q};
		end
		ent_rd_q <= ent_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		priority if (cmd.ins_write) begin
			wait_mem[tail_q] <= 1'b1;
		end else if (cmd.clear_wait) begin
			wait_mem[best_slot_q] <= 1'b0;
		end
		wait_rd_q <= wait_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			used_q      <= '0;
			next_arr_q  <= ARRIVAL_W'(1);
			iss_cnt_q   <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_write) begin
				tail_q     <= slot_next(tail_q);
				used_q     <= used_q + CW'(1);
				next_arr_q <= (next_arr_q == '1) ? ARRIVAL_W'(1) : next_arr_q + ARRIVAL_W'(1);
			end else if (cmd.trim_adv) begin
				head_q <= head_nxt;
				used_q <= used_q - CW'(1);
			end
			if (cmd.scan_start) begin
				iss_cnt_q <= cmd.scan_oldest ? CW'(1) : used_q;
			end else if (issue) begin
				iss_cnt_q <= iss_cnt_q - CW'(1);
			end
			rd_v_s1 <= issue;
			if (cmd.scan_start) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			prio_q <= prio_in;
		end
		if (cmd.scan_start) begin
			scan_ptr_q <= head_q;
		end else if (issue) begin
			scan_ptr_q <= slot_next(scan_ptr_q);
		end
		slot_s1 <= scan_ptr_q;
		if (take) begin
			best_prio_q <= rd_prio;
			best_arr_q  <= rd_arr;
			best_slot_q <= slot_s1;
		end
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			unique case (cmd.res_status)
				ST_INSERTED: number_q <= next_arr_q;
				ST_SERVED:   number_q <= best_arr_q;
				default:     number_q <= '0;
			endcase
		end
	end

	assign sts.full      = (used_q == CW'(DEPTH));
	assign sts.empty     = (used_q == '0);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.scan_done = (iss_cnt_q == '0) && !rd_v_s1;
	assign sts.trim_stop = (used_q == '0) || wait_rd_q;

	assign out_valid    = out_valid_q;
	assign entry_number = number_q;
	assign status       = status_q;

endmodule

[sv/fifo_and_priority_serve_queue.sv]
// Insert: S_INS loads the result when the output is free, then S_IDLE takes the next request.
// Serve oldest: S_SCAN reads the head slot and S_SERVE loads the result, then the head is trimmed.
// Serve highest priority: S_SCAN makes one table read per cycle over n = occupied ring slots,
// then S_SERVE loads the result; the head trim (S_TRIM_RD, S_TRIM_CHK) then skips served holes.
// A waiting result stalls only the final step of the next request.
// arst_n clears head, tail, count, arrival counter and output valid; table contents are not reset.
module fifo_and_priority_serve_queue
	import fpsq_pkg::*;
#(
	parameter int DEPTH         = DEPTH_DEF,
	parameter int PRIORITY_BITS = PRIO_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OPCODE_W-1:0]   opcode,
	input  logic [PRIO_REQ_W-1:0] priority_req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ARRIVAL_W-1:0]  entry_number,
	output logic [STATUS_W-1:0]   status
);

	cmd_t cmd;
	sts_t sts;

	fpsq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	fpsq_dpath #(
		.DEPTH         (DEPTH),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.priority_req (priority_req),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.entry_number (entry_number),
		.status       (status)
	);

endmodule

[sv/fpsq_checker.sv]
module fpsq_checker
	import fpsq_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [OPCODE_W-1:0]   opcode,
	input logic [PRIO_REQ_W-1:0] priority_req,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [ARRIVAL_W-1:0]  entry_number,
	input logic [STATUS_W-1:0]   status
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(opcode) && $stable(priority_req))
		else $error("request changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_number) && $stable(status))
		else $error("result changed while stalled");

	a_number_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_INSERTED || status == ST_SERVED) == (entry_number != '0)))
		else $error("entry number disagrees with status");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in progress");

endmodule

bind fifo_and_priority_serve_queue fpsq_checker u_fpsq_checker (.*);
